// ----- src/ffpa_pkg.sv -----
// ffpa_pkg: shared types, codes and defaults of the first-fit pool allocator
// depends on nothing; used by ffpa_stats, ffpa_ctrl and first_fit_pool_allocator
package ffpa_pkg;

   localparam int POOL_BYTES_DEF   = 65536;
   localparam int ALIGN_BYTES_DEF  = 8;
   localparam int HEADER_BYTES_DEF = 24;

   localparam int CFG_W      = 17;
   localparam int REQ_SIZE_W = 17;
   localparam int OFFSET_W   = 16;
   localparam int STATUS_W   = 3;
   localparam int STAT_SIZE_W = 17;
   localparam int TOTAL_W    = 32;
   localparam int NEED_W     = 18;
   localparam int MIN_POOL   = 64;
   localparam int CFG_LIMIT  = 131072;

   localparam logic [CFG_W-1:0] CFG_RESET = 17'h10000;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_ALLOC  = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_FREED  = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_FIT = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_DOUBLE = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_NULL   = 3'd4;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_EVAL,
      ST_HEAD,
      ST_FREE_EVAL,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic                   alloc_ok;
      logic                   free_ok;
      logic [STAT_SIZE_W-1:0] size;
   } stat_event_type;

endpackage

// ----- src/ffpa_hdr_mem.sv -----
// ffpa_hdr_mem: block header store, one write port, one registered read port
// depends on nothing
module ffpa_hdr_mem #(
   parameter int DEPTH = 8192,
   parameter int WIDTH = 18
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_idx,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_idx,
   input  logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_idx];
      end
   end

endmodule

// ----- src/ffpa_stats.sv -----
// ffpa_stats: live byte count and saturating totals of the allocator
// depends on ffpa_pkg
module ffpa_stats
   import ffpa_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   clear,
   input  stat_event_type         event_in,
   output logic [STAT_SIZE_W-1:0] live_bytes,
   output logic                   leak_present,
   output logic [TOTAL_W-1:0]     allocated_total,
   output logic [TOTAL_W-1:0]     freed_total,
   output logic [TOTAL_W-1:0]     grant_count,
   output logic [TOTAL_W-1:0]     release_count
);

   logic [STAT_SIZE_W-1:0] live_ff, live_in;
   logic [TOTAL_W-1:0]     alloc_sum_ff, alloc_sum_in;
   logic [TOTAL_W-1:0]     free_sum_ff, free_sum_in;
   logic [TOTAL_W-1:0]     alloc_ops_ff, alloc_ops_in;
   logic [TOTAL_W-1:0]     free_ops_ff, free_ops_in;
   logic [STAT_SIZE_W:0]   live_add;
   logic [TOTAL_W:0]       size_add_a, size_add_f, ops_add_a, ops_add_f;

   always_comb begin
      live_add   = {1'b0, live_ff} + {1'b0, event_in.size};
      size_add_a = {1'b0, alloc_sum_ff} + {{(TOTAL_W-STAT_SIZE_W+1){1'b0}}, event_in.size};
      size_add_f = {1'b0, free_sum_ff} + {{(TOTAL_W-STAT_SIZE_W+1){1'b0}}, event_in.size};
      ops_add_a  = {1'b0, alloc_ops_ff} + (TOTAL_W+1)'(1);
      ops_add_f  = {1'b0, free_ops_ff} + (TOTAL_W+1)'(1);
      live_in      = live_ff;
      alloc_sum_in = alloc_sum_ff;
      free_sum_in  = free_sum_ff;
      alloc_ops_in = alloc_ops_ff;
      free_ops_in  = free_ops_ff;
      if (clear) begin
         live_in      = '0;
         alloc_sum_in = '0;
         free_sum_in  = '0;
         alloc_ops_in = '0;
         free_ops_in  = '0;
      end else if (event_in.alloc_ok) begin
         live_in      = live_add[STAT_SIZE_W] ? '1 : live_add[STAT_SIZE_W-1:0];
         alloc_sum_in = size_add_a[TOTAL_W] ? '1 : size_add_a[TOTAL_W-1:0];
         alloc_ops_in = ops_add_a[TOTAL_W] ? '1 : ops_add_a[TOTAL_W-1:0];
      end else if (event_in.free_ok) begin
         live_in     = (live_ff >= event_in.size) ? live_ff - event_in.size : '0;
         free_sum_in = size_add_f[TOTAL_W] ? '1 : size_add_f[TOTAL_W-1:0];
         free_ops_in = ops_add_f[TOTAL_W] ? '1 : ops_add_f[TOTAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff      <= '0;
         alloc_sum_ff <= '0;
         free_sum_ff  <= '0;
         alloc_ops_ff <= '0;
         free_ops_ff  <= '0;
      end else begin
         live_ff      <= live_in;
         alloc_sum_ff <= alloc_sum_in;
         free_sum_ff  <= free_sum_in;
         alloc_ops_ff <= alloc_ops_in;
         free_ops_ff  <= free_ops_in;
      end
   end

   assign live_bytes      = live_ff;
   assign leak_present    = (live_ff != '0);
   assign allocated_total = alloc_sum_ff;
   assign freed_total     = free_sum_ff;
   assign grant_count     = alloc_ops_ff;
   assign release_count   = free_ops_ff;

endmodule

// ----- src/ffpa_ctrl.sv -----
// ffpa_ctrl: sequencer for header clearing, first-fit walk, split and free
// depends on ffpa_pkg; drives ffpa_hdr_mem and ffpa_stats
module ffpa_ctrl
   import ffpa_pkg::*;
#(
   parameter int POOL_BYTES   = POOL_BYTES_DEF,
   parameter int ALIGN_BYTES  = ALIGN_BYTES_DEF,
   parameter int HEADER_BYTES = HEADER_BYTES_DEF,
   parameter int DEPTH        = 8192,
   parameter int IDX_W        = 13,
   parameter int SZ_W         = 16,
   parameter int LEN_W        = 17,
   parameter int GRAIN_LG     = 3
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CFG_W-1:0]      csr_wr_data,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_action,
   input  logic [REQ_SIZE_W-1:0] req_request_size,
   input  logic [OFFSET_W-1:0]   req_block_offset,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [OFFSET_W-1:0]   rsp_payload_offset,
   output logic [STAT_SIZE_W-1:0] rsp_granted_size,
   output logic                  mem_rd_en,
   output logic [IDX_W-1:0]      mem_rd_idx,
   input  logic [SZ_W+1:0]       mem_rd_data,
   output logic                  mem_wr_en,
   output logic [IDX_W-1:0]      mem_wr_idx,
   output logic [SZ_W+1:0]       mem_wr_data,
   output logic                  stat_clear,
   output stat_event_type        stat_event
);

   localparam int PB_W = $clog2(POOL_BYTES + 1);
   localparam int CW   = ((PB_W > NEED_W) ? PB_W : NEED_W) + 1;
   localparam int XW   = ((LEN_W > NEED_W) ? LEN_W : NEED_W) + 2;

   ctrl_state_type state_ff, state_in;

   logic [CFG_W-1:0]    cfg_ff;
   logic [IDX_W-1:0]    clr_cnt_ff;
   logic [NEED_W-1:0]   need_ff;
   logic [LEN_W-1:0]    off_ff;
   logic [IDX_W-1:0]    fidx_ff;
   logic [STATUS_W-1:0] st_ff;
   logic [OFFSET_W-1:0] pay_ff;
   logic [SZ_W-1:0]     grant_ff;
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [OFFSET_W-1:0] rsp_pay_ff;
   logic [SZ_W-1:0]     rsp_grant_ff;

   logic [CW-1:0]     p_clamp, p_align, p_fin;
   logic [LEN_W-1:0]  pool_len;
   logic [NEED_W-1:0] need_calc;
   logic [XW-1:0]     off_x, size_x, need_x, len_x, hdr_x, nb_x, next_x;
   logic              walk_end, fits, split;
   logic              rd_valid, rd_free;
   logic [SZ_W-1:0]   rd_size;
   logic [OFFSET_W-1:0] fhdr;
   logic              free_bad;
   logic [XW-1:0]     fhdr_x;
   logic              accept, slot_free, finish;

   // pool length from the size register
   always_comb begin
      p_clamp = CW'(cfg_ff);
      if (p_clamp < CW'(MIN_POOL)) begin
         p_clamp = CW'(MIN_POOL);
      end
      if (p_clamp > CW'(POOL_BYTES)) begin
         p_clamp = CW'(POOL_BYTES);
      end
      p_align = (p_clamp + CW'(ALIGN_BYTES - 1)) & ~CW'(ALIGN_BYTES - 1);
      p_fin   = p_align;
      if (p_align > CW'(POOL_BYTES)) begin
         p_fin = CW'(POOL_BYTES) & ~CW'(ALIGN_BYTES - 1);
      end
      pool_len = p_fin[LEN_W-1:0];
   end

   always_comb begin
      need_calc = (NEED_W'(req_request_size) + NEED_W'(ALIGN_BYTES - 1))
                  & ~NEED_W'(ALIGN_BYTES - 1);
      rd_valid = mem_rd_data[SZ_W+1];
      rd_free  = mem_rd_data[SZ_W];
      rd_size  = mem_rd_data[SZ_W-1:0];
      off_x    = XW'(off_ff);
      size_x   = XW'(rd_size);
      need_x   = XW'(need_ff);
      len_x    = XW'(pool_len);
      hdr_x    = XW'(HEADER_BYTES);
      walk_end = (off_x + hdr_x) > len_x;
      fits     = rd_valid && rd_free && (size_x >= need_x);
      split    = size_x >= (need_x + hdr_x + XW'(ALIGN_BYTES));
      nb_x     = off_x + hdr_x + need_x;
      next_x   = off_x + hdr_x + size_x;
      fhdr     = req_block_offset - OFFSET_W'(HEADER_BYTES);
      fhdr_x   = XW'(fhdr);
      free_bad = (req_block_offset == '0)
                 || (XW'(req_block_offset) < hdr_x)
                 || (fhdr_x >= len_x)
                 || (fhdr[GRAIN_LG-1:0] != '0);
      accept    = req_valid && req_ready;
      slot_free = !rsp_valid_ff || rsp_ready;
      finish    = (state_ff == ST_DONE) && slot_free;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == IDX_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_action == ACT_ALLOC) begin
                  state_in = ST_WALK;
               end else if (free_bad) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_FREE_EVAL;
               end
            end
         end
         ST_WALK: begin
            state_in = walk_end ? ST_DONE : ST_EVAL;
         end
         ST_EVAL: begin
            if (!rd_valid) begin
               state_in = ST_DONE;
            end else if (fits) begin
               state_in = ST_HEAD;
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_HEAD:      state_in = ST_DONE;
         ST_FREE_EVAL: state_in = ST_DONE;
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
      if (csr_wr_en) begin
         state_in = ST_CLEAR;
      end
   end

   // outputs
   always_comb begin
      req_ready   = (state_ff == ST_IDLE) && !csr_wr_en;
      mem_rd_en   = 1'b0;
      mem_rd_idx  = off_ff[IDX_W+GRAIN_LG-1:GRAIN_LG];
      mem_wr_en   = 1'b0;
      mem_wr_idx  = off_ff[IDX_W+GRAIN_LG-1:GRAIN_LG];
      mem_wr_data = '0;
      stat_clear  = csr_wr_en;
      stat_event.alloc_ok = finish && (st_ff == STATUS_ALLOC);
      stat_event.free_ok  = finish && (st_ff == STATUS_FREED);
      stat_event.size     = STAT_SIZE_W'(grant_ff);
      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en  = 1'b1;
            mem_wr_idx = clr_cnt_ff;
            if (clr_cnt_ff == '0) begin
               mem_wr_data = {1'b1, 1'b1, SZ_W'(pool_len - LEN_W'(HEADER_BYTES))};
            end
         end
         ST_IDLE: begin
            mem_rd_en  = accept && (req_action == ACT_FREE) && !free_bad;
            mem_rd_idx = fhdr[IDX_W+GRAIN_LG-1:GRAIN_LG];
         end
         ST_WALK: begin
            mem_rd_en = !walk_end;
         end
         ST_EVAL: begin
            if (fits && split) begin
               mem_wr_en   = 1'b1;
               mem_wr_idx  = nb_x[IDX_W+GRAIN_LG-1:GRAIN_LG];
               mem_wr_data = {1'b1, 1'b1, SZ_W'(size_x - need_x - hdr_x)};
            end
         end
         ST_HEAD: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = {1'b1, 1'b0, grant_ff};
         end
         ST_FREE_EVAL: begin
            mem_wr_en   = rd_valid && !rd_free;
            mem_wr_idx  = fidx_ff;
            mem_wr_data = {1'b1, 1'b1, rd_size};
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cfg_ff       <= CFG_RESET;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            cfg_ff     <= csr_wr_data;
            clr_cnt_ff <= '0;
         end else if (state_ff == ST_CLEAR) begin
            clr_cnt_ff <= clr_cnt_ff + IDX_W'(1);
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // item work registers
   always_ff @(posedge clock) begin
      if (accept) begin
         need_ff  <= need_calc;
         off_ff   <= '0;
         fidx_ff  <= fhdr[IDX_W+GRAIN_LG-1:GRAIN_LG];
         st_ff    <= (req_action == ACT_ALLOC) ? STATUS_NO_FIT : STATUS_NULL;
         pay_ff   <= '0;
         grant_ff <= '0;
      end
      if (state_ff == ST_EVAL && rd_valid) begin
         if (fits) begin
            st_ff    <= STATUS_ALLOC;
            pay_ff   <= OFFSET_W'(off_x + hdr_x);
            grant_ff <= split ? SZ_W'(need_ff) : rd_size;
         end else begin
            off_ff <= next_x[LEN_W-1:0];
         end
      end
      if (state_ff == ST_FREE_EVAL && rd_valid) begin
         if (rd_free) begin
            st_ff <= STATUS_DOUBLE;
         end else begin
            st_ff    <= STATUS_FREED;
            grant_ff <= rd_size;
         end
      end
      if (finish) begin
         rsp_status_ff <= st_ff;
         rsp_pay_ff    <= pay_ff;
         rsp_grant_ff  <= grant_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_payload_offset = rsp_pay_ff;
   assign rsp_granted_size   = STAT_SIZE_W'(rsp_grant_ff);

endmodule

// ----- src/first_fit_pool_allocator.sv -----
// first_fit_pool_allocator: first-fit pool allocator with block splitting
// an allocate reads and checks each block (ST_WALK, ST_EVAL), then writes a grant (ST_HEAD)
// a free reads the header and frees it in ST_FREE_EVAL; a null or bad offset goes to ST_DONE
// one item in flight; a waiting result does not block input, but the next waits in ST_DONE
// after reset and after every csr write the header store is cleared, one entry per cycle,
// all DEPTH entries (8192 with default parameters), req_ready low during the pass
module first_fit_pool_allocator
   import ffpa_pkg::*;
#(
   parameter int POOL_BYTES   = POOL_BYTES_DEF,
   parameter int ALIGN_BYTES  = ALIGN_BYTES_DEF,
   parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CFG_W-1:0]       csr_wr_data,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_action,
   input  logic [REQ_SIZE_W-1:0]  req_request_size,
   input  logic [OFFSET_W-1:0]    req_block_offset,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [OFFSET_W-1:0]    rsp_payload_offset,
   output logic [STAT_SIZE_W-1:0] rsp_granted_size,
   output logic [STAT_SIZE_W-1:0] rsp_live_bytes,
   output logic                   rsp_leak_present,
   output logic [TOTAL_W-1:0]     rsp_allocated_total,
   output logic [TOTAL_W-1:0]     rsp_freed_total,
   output logic [TOTAL_W-1:0]     rsp_grant_count,
   output logic [TOTAL_W-1:0]     rsp_release_count
);

   localparam int HDR_LOW  = HEADER_BYTES & -HEADER_BYTES;
   localparam int GRAIN    = (HDR_LOW < ALIGN_BYTES) ? HDR_LOW : ALIGN_BYTES;
   localparam int GRAIN_LG = $clog2(GRAIN);
   localparam int POOL_MAX = (POOL_BYTES < CFG_LIMIT) ? POOL_BYTES : CFG_LIMIT;
   localparam int DEPTH    = (POOL_MAX + GRAIN - 1) / GRAIN;
   localparam int IDX_W    = $clog2(DEPTH);
   localparam int SZ_W     = $clog2(POOL_MAX);
   localparam int LEN_W    = $clog2(POOL_MAX + 1);

   logic             mem_rd_en, mem_wr_en;
   logic [IDX_W-1:0] mem_rd_idx, mem_wr_idx;
   logic [SZ_W+1:0]  mem_rd_data, mem_wr_data;
   logic             stat_clear;
   stat_event_type   stat_event;

   ffpa_hdr_mem #(
      .DEPTH (DEPTH),
      .WIDTH (SZ_W + 2)
   ) u_hdr_mem (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_idx  (mem_rd_idx),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_idx  (mem_wr_idx),
      .wr_data (mem_wr_data)
   );

   ffpa_stats u_stats (
      .clock           (clock),
      .reset           (reset),
      .clear           (stat_clear),
      .event_in        (stat_event),
      .live_bytes      (rsp_live_bytes),
      .leak_present    (rsp_leak_present),
      .allocated_total (rsp_allocated_total),
      .freed_total     (rsp_freed_total),
      .grant_count     (rsp_grant_count),
      .release_count   (rsp_release_count)
   );

   ffpa_ctrl #(
      .POOL_BYTES   (POOL_BYTES),
      .ALIGN_BYTES  (ALIGN_BYTES),
      .HEADER_BYTES (HEADER_BYTES),
      .DEPTH        (DEPTH),
      .IDX_W        (IDX_W),
      .SZ_W         (SZ_W),
      .LEN_W        (LEN_W),
      .GRAIN_LG     (GRAIN_LG)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_request_size   (req_request_size),
      .req_block_offset   (req_block_offset),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_payload_offset (rsp_payload_offset),
      .rsp_granted_size   (rsp_granted_size),
      .mem_rd_en          (mem_rd_en),
      .mem_rd_idx         (mem_rd_idx),
      .mem_rd_data        (mem_rd_data),
      .mem_wr_en          (mem_wr_en),
      .mem_wr_idx         (mem_wr_idx),
      .mem_wr_data        (mem_wr_data),
      .stat_clear         (stat_clear),
      .stat_event         (stat_event)
   );

endmodule
